// ===== rtl/core/dcgl_pkg.sv =====
// shared types, constants and helpers of the dithered gradient line generator
`default_nettype none
package dcgl_pkg;

	localparam int unsigned MAX_LINE = 4096;
	localparam int unsigned LEN_W = 13;
	localparam int unsigned COLOR_W = 32;
	localparam int unsigned IN_DATA_W = 80;
	localparam int unsigned NUM_CHAN = 4;
	localparam int unsigned CHAN_W = 2;
	localparam int unsigned LANE_W = 16;

	// divider: |diff| << 16 needs 24 bits, length - 1 needs 12 bits
	localparam int unsigned DIV_W = 24;
	localparam int unsigned DVS_W = 12;
	localparam int unsigned DIV_STEPS = 24;
	localparam int unsigned DIV_CNT_W = 5;

	localparam logic [LANE_W-1:0] DITHER_MUL = 16'hbb75;

	localparam logic [LANE_W-1:0] LANE0_RST = 16'hbcdd;
	localparam logic [LANE_W-1:0] LANE1_RST = 16'h56c9;
	localparam logic [LANE_W-1:0] LANE2_RST = 16'h8785;
	localparam logic [LANE_W-1:0] LANE3_RST = 16'ha9d1;

	localparam logic KIND_BEGIN = 1'b0;
	localparam logic KIND_PIXEL = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV_ISSUE,
		ST_DIV_WAIT,
		ST_PIXEL,
		ST_OUT
	} seq_state_t;

	// channel order alpha, red, green, blue; dither lane that feeds each one
	function automatic logic [CHAN_W-1:0] lane_of(input logic [CHAN_W-1:0] chan);
		logic [CHAN_W-1:0] lane;
		case (chan)
			2'd0: lane = 2'd1;
			2'd1: lane = 2'd3;
			2'd2: lane = 2'd0;
			default: lane = 2'd2;
		endcase
		return lane;
	endfunction

	// signed 16-bit integer part clamped to 0..255
	function automatic logic [7:0] clamp_chan(input logic [31:0] sum);
		logic [7:0] res;
		if (sum[31]) begin
			res = 8'd0;
		end else if (|sum[30:24]) begin
			res = 8'hff;
		end else begin
			res = sum[23:16];
		end
		return res;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/dcgl_div.sv =====
// restoring unsigned divider, one quotient bit per cycle
`default_nettype none
module dcgl_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [dcgl_pkg::DIV_W-1:0]  dividend,
	input  wire logic [dcgl_pkg::DVS_W-1:0]  divisor,
	output logic                             done,
	output logic [dcgl_pkg::DIV_W-1:0]       quotient
);

	logic                           busy_q;
	logic                           done_q;
	logic [dcgl_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [dcgl_pkg::DVS_W-1:0]     rem_q;
	logic [dcgl_pkg::DIV_W-1:0]     quo_q;
	logic [dcgl_pkg::DVS_W-1:0]     dvs_q;

	logic [dcgl_pkg::DVS_W:0] shifted;
	logic [dcgl_pkg::DVS_W:0] trial;
	logic                     ge;

	assign shifted = {rem_q, quo_q[dcgl_pkg::DIV_W-1]};
	assign ge      = shifted >= {1'b0, dvs_q};
	assign trial   = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == dcgl_pkg::DIV_CNT_W'(dcgl_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// quotient bits shift in where the dividend bits shift out
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? trial[dcgl_pkg::DVS_W-1:0] : shifted[dcgl_pkg::DVS_W-1:0];
			quo_q <= {quo_q[dcgl_pkg::DIV_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

// ===== rtl/core/dithered_color_gradient_line.sv =====
// top level: sequencer, channel state, dither lanes and output register
//
// channel | signals                           | payload
// s_axis  | s_tvalid s_tready s_tdata s_tuser | kind, start/end color, line length
// m_axis  | m_tvalid m_tready m_tdata m_tlast | dithered pixel, last pixel of line
//
// a pixel transfer steps through accept, one step per channel through the
// shared lane multiplier and accumulator adder, then the output register load.
// a begin transfer goes, after accept, through issue, the 24-bit quotient and done
// of the serial divider per channel, or only issue for lines shorter than two.
// a pixel transfer with no pixels left is accepted and gives nothing.
// s_tready is high only in idle; a full output register stalls only the load cycle.
`default_nettype none
module dithered_color_gradient_line (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	// [31:0] start_color, [63:32] end_color, [76:64] line_length, [79:77] zero
	input  wire logic [dcgl_pkg::IN_DATA_W-1:0]    s_tdata,
	// [0] kind
	input  wire logic                              s_tuser,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// [31:0] pixel_color
	output logic [dcgl_pkg::COLOR_W-1:0]           m_tdata,
	output logic                                   m_tlast
);

	dcgl_pkg::seq_state_t state_q, state_d;

	logic [dcgl_pkg::CHAN_W-1:0]  chan_q;
	logic [dcgl_pkg::LEN_W-1:0]   pixels_left_q;
	logic                         short_q;
	logic [dcgl_pkg::COLOR_W-1:0] start_q;
	logic [dcgl_pkg::COLOR_W-1:0] end_q;
	logic [dcgl_pkg::DVS_W-1:0]   dvs_q;
	logic [dcgl_pkg::COLOR_W-1:0] color_q;
	logic [31:0]                  acc_q   [dcgl_pkg::NUM_CHAN];
	logic [31:0]                  step_q  [dcgl_pkg::NUM_CHAN];
	logic [dcgl_pkg::LANE_W-1:0]  lane_q  [dcgl_pkg::NUM_CHAN];

	logic                         m_tvalid_q;
	logic [dcgl_pkg::COLOR_W-1:0] m_tdata_q;
	logic                         m_tlast_q;

	logic                         in_xfer;
	logic                         out_free;
	logic [dcgl_pkg::LEN_W-1:0]   len_in;
	logic [dcgl_pkg::LEN_W-1:0]   len_cl;

	logic [4:0]                   byte_sel;
	logic [7:0]                   cs;
	logic [7:0]                   ce;
	logic                         diff_neg;
	logic [7:0]                   diff_mag;
	logic [dcgl_pkg::DIV_W-1:0]   dividend;
	logic [dcgl_pkg::DIV_W-1:0]   step_mag;
	logic [31:0]                  step_val;

	logic                         div_start;
	logic                         div_done;
	logic [dcgl_pkg::DIV_W-1:0]   div_quotient;

	logic [dcgl_pkg::CHAN_W-1:0]  lane_idx;
	logic [31:0]                  lane_prod;
	logic [dcgl_pkg::LANE_W-1:0]  lane_next;
	logic [31:0]                  chan_sum;
	logic [7:0]                   chan_byte;

	logic                         step_wr;

	assign in_xfer  = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign len_in   = s_tdata[76:64];
	assign len_cl   = (len_in > dcgl_pkg::LEN_W'(dcgl_pkg::MAX_LINE)) ?
		dcgl_pkg::LEN_W'(dcgl_pkg::MAX_LINE) : len_in;

	// per-channel difference for the step being set up
	assign byte_sel = {~chan_q, 3'b000};
	assign cs       = 8'(start_q >> byte_sel);
	assign ce       = 8'(end_q >> byte_sel);
	assign diff_neg = ce < cs;
	assign diff_mag = diff_neg ? (cs - ce) : (ce - cs);
	assign dividend = {diff_mag, 16'h0000};
	assign step_mag = short_q ? dividend : div_quotient;
	assign step_val = diff_neg ? (32'd0 - {8'd0, step_mag}) : {8'd0, step_mag};

	// pixel datapath, one channel per cycle
	assign lane_idx  = dcgl_pkg::lane_of(chan_q);
	assign lane_prod = {16'd0, lane_q[lane_idx]} * {16'd0, dcgl_pkg::DITHER_MUL};
	assign lane_next = lane_prod[dcgl_pkg::LANE_W-1:0];
	assign chan_sum  = acc_q[chan_q] + {16'd0, lane_next};
	assign chan_byte = dcgl_pkg::clamp_chan(chan_sum);

	dcgl_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (dvs_q),
		.done     (div_done),
		.quotient (div_quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dcgl_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		div_start = 1'b0;
		step_wr   = 1'b0;
		case (state_q)
			dcgl_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (in_xfer) begin
					if (s_tuser == dcgl_pkg::KIND_BEGIN) begin
						state_d = dcgl_pkg::ST_DIV_ISSUE;
					end else if (pixels_left_q != '0) begin
						state_d = dcgl_pkg::ST_PIXEL;
					end
				end
			end
			dcgl_pkg::ST_DIV_ISSUE: begin
				if (short_q) begin
					step_wr = 1'b1;
					if (chan_q == dcgl_pkg::CHAN_W'(dcgl_pkg::NUM_CHAN - 1)) begin
						state_d = dcgl_pkg::ST_IDLE;
					end
				end else begin
					div_start = 1'b1;
					state_d   = dcgl_pkg::ST_DIV_WAIT;
				end
			end
			dcgl_pkg::ST_DIV_WAIT: begin
				if (div_done) begin
					step_wr = 1'b1;
					if (chan_q == dcgl_pkg::CHAN_W'(dcgl_pkg::NUM_CHAN - 1)) begin
						state_d = dcgl_pkg::ST_IDLE;
					end else begin
						state_d = dcgl_pkg::ST_DIV_ISSUE;
					end
				end
			end
			dcgl_pkg::ST_PIXEL: begin
				if (chan_q == dcgl_pkg::CHAN_W'(dcgl_pkg::NUM_CHAN - 1)) begin
					state_d = dcgl_pkg::ST_OUT;
				end
			end
			dcgl_pkg::ST_OUT: begin
				if (out_free) begin
					state_d = dcgl_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = dcgl_pkg::ST_IDLE;
			end
		endcase
	end

	// control and channel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_q        <= '0;
			pixels_left_q <= '0;
			for (int i = 0; i < dcgl_pkg::NUM_CHAN; i++) begin
				acc_q[i]  <= '0;
				step_q[i] <= '0;
			end
			lane_q[0] <= dcgl_pkg::LANE0_RST;
			lane_q[1] <= dcgl_pkg::LANE1_RST;
			lane_q[2] <= dcgl_pkg::LANE2_RST;
			lane_q[3] <= dcgl_pkg::LANE3_RST;
		end else begin
			if (state_q == dcgl_pkg::ST_IDLE && in_xfer) begin
				chan_q <= '0;
				if (s_tuser == dcgl_pkg::KIND_BEGIN) begin
					pixels_left_q <= len_cl;
					for (int i = 0; i < dcgl_pkg::NUM_CHAN; i++) begin
						acc_q[i] <= {8'd0, s_tdata[8*(3-i) +: 8], 16'h0000};
					end
				end
			end
			if (step_wr) begin
				step_q[chan_q] <= step_val;
				chan_q         <= chan_q + 1'b1;
			end
			if (state_q == dcgl_pkg::ST_PIXEL) begin
				lane_q[lane_idx] <= lane_next;
				acc_q[chan_q]    <= acc_q[chan_q] + step_q[chan_q];
				chan_q           <= chan_q + 1'b1;
				if (chan_q == dcgl_pkg::CHAN_W'(dcgl_pkg::NUM_CHAN - 1)) begin
					pixels_left_q <= pixels_left_q - 1'b1;
				end
			end
		end
	end

	// line parameters and pixel assembly
	always_ff @(posedge clk) begin
		if (state_q == dcgl_pkg::ST_IDLE && in_xfer
				&& s_tuser == dcgl_pkg::KIND_BEGIN) begin
			start_q <= s_tdata[31:0];
			end_q   <= s_tdata[63:32];
			short_q <= len_cl < dcgl_pkg::LEN_W'(2);
			dvs_q   <= dcgl_pkg::DVS_W'(len_cl - 1'b1);
		end
		if (state_q == dcgl_pkg::ST_PIXEL) begin
			color_q[{~chan_q, 3'b000} +: 8] <= chan_byte;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == dcgl_pkg::ST_OUT && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == dcgl_pkg::ST_OUT && out_free) begin
			m_tdata_q <= color_q;
			m_tlast_q <= pixels_left_q == '0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

`ifndef SYNTH
	a_pixel_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == dcgl_pkg::ST_PIXEL |-> pixels_left_q != '0)
		else $error("pixel sequence running with no pixels left");

	a_div_only_long: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == dcgl_pkg::ST_DIV_WAIT |-> !short_q)
		else $error("divider used for a line shorter than two pixels");

	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q) == dcgl_pkg::ST_OUT)
		else $error("output transfer raised outside the output load");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == dcgl_pkg::ST_IDLE |=>
			pixels_left_q <= dcgl_pkg::LEN_W'(dcgl_pkg::MAX_LINE))
		else $error("pixel count above the line limit");
`endif

endmodule
`default_nettype wire

// ===== test/gradient_pixel_checker.sv =====
// checker for the gradient line generator: predicts dithered pixels and compares them
module gradient_pixel_checker (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	input  wire logic                           s_tready,
	// [31:0] start_color, [63:32] end_color, [76:64] line_length, [79:77] zero
	input  wire logic [dcgl_pkg::IN_DATA_W-1:0] s_tdata,
	// [0] kind
	input  wire logic                           s_tuser,
	input  wire logic                           m_tvalid,
	input  wire logic                           m_tready,
	// [31:0] pixel_color
	input  wire logic [dcgl_pkg::COLOR_W-1:0]   m_tdata,
	input  wire logic                           m_tlast,
	output int                                  fail_count,
	output int                                  pixels_pending,
	output int                                  lines_begun,
	output int                                  pixel_requests,
	output int                                  pixels_compared,
	output int                                  line_ends
);
	timeunit 1ns;
	timeprecision 1ps;
	import dcgl_pkg::*;

	typedef struct packed {
		logic [31:0] color;
		logic        last;
	} pixel_t;

	// dither lane feeding alpha, red, green, blue (two bits each, alpha lowest)
	localparam logic [7:0] LANE_FEED = {2'd2, 2'd0, 2'd3, 2'd1};

	logic [31:0] chan_acc [4];
	logic [31:0] chan_step [4];
	logic [15:0] dither [4];
	logic [12:0] pixels_left;
	pixel_t      expected_pixels [$];
	pixel_t      oldest;

	task automatic note_failure(input string what);
		fail_count++;
		if (fail_count <= 10) begin
			$display("%t mismatch: %s", $realtime, what);
		end
	endtask

	task automatic begin_line(input logic [31:0] from_color, input logic [31:0] to_color,
			input logic [12:0] len);
		logic [12:0] n;
		int          cs;
		int          ce;
		int          diff;
		n = (len > 13'(MAX_LINE)) ? 13'(MAX_LINE) : len;
		for (int c = 0; c < 4; c++) begin
			cs = int'((from_color >> (24 - 8 * c)) & 32'hff);
			ce = int'((to_color >> (24 - 8 * c)) & 32'hff);
			diff = (ce - cs) * 65536;
			// signed division truncates toward zero
			if (n >= 13'd2) begin
				diff = diff / (int'(n) - 1);
			end
			chan_acc[c] = 32'(cs) << 16;
			chan_step[c] = diff;
		end
		pixels_left = n;
	endtask

	task automatic next_pixel();
		logic [31:0] sum;
		logic [31:0] color;
		logic [15:0] whole;
		logic [7:0]  level;
		if (pixels_left == 13'd0) begin
			return;
		end
		for (int i = 0; i < 4; i++) begin
			dither[i] = dither[i] * DITHER_MUL;
		end
		color = '0;
		for (int c = 0; c < 4; c++) begin
			sum = chan_acc[c] + {16'h0000, dither[LANE_FEED[2*c +: 2]]};
			whole = sum[31:16];
			if (whole[15]) begin
				level = 8'h00;
			end else if (whole > 16'd255) begin
				level = 8'hff;
			end else begin
				level = whole[7:0];
			end
			color = color | ({24'h0, level} << (24 - 8 * c));
			chan_acc[c] = chan_acc[c] + chan_step[c];
		end
		pixels_left = pixels_left - 13'd1;
		expected_pixels.push_back('{color: color, last: (pixels_left == 13'd0)});
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < 4; c++) begin
				chan_acc[c] = '0;
				chan_step[c] = '0;
			end
			dither[0] = LANE0_RST;
			dither[1] = LANE1_RST;
			dither[2] = LANE2_RST;
			dither[3] = LANE3_RST;
			pixels_left = '0;
			expected_pixels.delete();
			fail_count = 0;
			pixels_pending = 0;
			lines_begun = 0;
			pixel_requests = 0;
			pixels_compared = 0;
			line_ends = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_pixels.size() == 0) begin
					note_failure($sformatf("pixel %08h last %0b with none expected",
						m_tdata, m_tlast));
				end else begin
					oldest = expected_pixels.pop_front();
					pixels_compared++;
					if (oldest.last) begin
						line_ends++;
					end
					if (m_tdata !== oldest.color || m_tlast !== oldest.last) begin
						note_failure($sformatf("pixel %08h last %0b, expected %08h last %0b",
							m_tdata, m_tlast, oldest.color, oldest.last));
					end
				end
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser == KIND_BEGIN) begin
					lines_begun++;
					begin_line(s_tdata[31:0], s_tdata[63:32], s_tdata[76:64]);
				end else begin
					pixel_requests++;
					next_pixel();
				end
			end
			pixels_pending = expected_pixels.size();
		end
	end

endmodule

// ===== test/tb_top.sv =====
// testbench top: stimulus, handshake pressure and verdict for the gradient line generator
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import dcgl_pkg::*;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic [IN_DATA_W-1:0] s_tdata = '0;
	logic                 s_tuser = 1'b0;
	logic                 m_tready = 1'b0;
	logic                 s_tready;
	logic                 m_tvalid;
	logic [COLOR_W-1:0]   m_tdata;
	logic                 m_tlast;

	int send_idle_pct = 9;
	int take_stall_pct = 55;
	int fail_count;
	int pixels_pending;
	int lines_begun;
	int pixel_requests;
	int pixels_compared;
	int line_ends;

	always #1 clk = ~clk;

	dithered_color_gradient_line i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	gradient_pixel_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tuser         (s_tuser),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.m_tlast         (m_tlast),
		.fail_count      (fail_count),
		.pixels_pending  (pixels_pending),
		.lines_begun     (lines_begun),
		.pixel_requests  (pixel_requests),
		.pixels_compared (pixels_compared),
		.line_ends       (line_ends)
	);

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= take_stall_pct);
	end

	task automatic send_item(input logic kind, input logic [31:0] from_color,
			input logic [31:0] to_color, input logic [12:0] len);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {3'b000, len, to_color, from_color};
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
	endtask

	// bytes often pinned to black or full level to hit the clamp edges
	function automatic logic [31:0] rand_color();
		logic [31:0] color;
		color = $urandom;
		for (int b = 0; b < 4; b++) begin
			case ($urandom_range(7))
				0: color[8*b +: 8] = 8'h00;
				1: color[8*b +: 8] = 8'hff;
				default: ;
			endcase
		end
		return color;
	endfunction

	task automatic random_lines(input int target);
		int          counted;
		int          full;
		int          n;
		int          pick;
		logic [12:0] len;
		counted = 0;
		while (counted < target) begin
			pick = $urandom_range(99);
			if (pick < 5) begin
				len = 13'($urandom_range(1));
			end else if (pick < 80) begin
				len = 13'($urandom_range(24, 2));
			end else if (pick < 95) begin
				len = 13'($urandom_range(200, 25));
			end else begin
				len = 13'($urandom_range(8191, 4096));
			end
			full = (len > 13'(MAX_LINE)) ? MAX_LINE : int'(len);
			send_item(KIND_BEGIN, rand_color(), rand_color(), len);
			counted++;
			// mostly whole lines, some cut short, some running past the end
			pick = $urandom_range(99);
			if (full >= MAX_LINE) begin
				n = $urandom_range(40, 1);
			end else if (pick < 70) begin
				n = full;
			end else if (pick < 85) begin
				n = $urandom_range(full);
			end else begin
				n = full + $urandom_range(3, 1);
			end
			repeat (n) begin
				send_item(KIND_PIXEL, $urandom, $urandom, 13'($urandom));
			end
			counted += (n < full) ? n : full;
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// pixel request right after reset and on an empty line
		send_item(KIND_PIXEL, 32'hffffffff, 32'hffffffff, 13'h1fff);
		send_item(KIND_BEGIN, 32'h00000000, 32'hffffffff, 13'd0);
		send_item(KIND_PIXEL, 32'h00000000, 32'h00000000, 13'd0);
		// single pixel line with the undivided difference
		send_item(KIND_BEGIN, 32'h00000000, 32'hffffffff, 13'd1);
		send_item(KIND_PIXEL, 32'h0, 32'h0, 13'd0);
		send_item(KIND_PIXEL, 32'h0, 32'h0, 13'd0);
		// full swing downward over two pixels
		send_item(KIND_BEGIN, 32'hffffffff, 32'h00000000, 13'd2);
		repeat (3) send_item(KIND_PIXEL, 32'h0, 32'h0, 13'd0);
		// length above the maximum is clamped
		send_item(KIND_BEGIN, 32'h00ff00ff, 32'hff00ff00, 13'h1fff);
		repeat (2) send_item(KIND_PIXEL, 32'h0, 32'h0, 13'd0);
		send_item(KIND_BEGIN, 32'hff00ff00, 32'h00ff00ff, 13'(MAX_LINE));
		send_item(KIND_PIXEL, 32'h0, 32'h0, 13'd0);
		send_item(KIND_BEGIN, 32'h12345678, 32'h87654321, 13'd3);
		repeat (3) send_item(KIND_PIXEL, 32'h0, 32'h0, 13'd0);
		// flat full level, the dither only reaches the fraction and the level stays 255
		send_item(KIND_BEGIN, 32'hffffffff, 32'hffffffff, 13'd5);
		repeat (5) send_item(KIND_PIXEL, 32'h0, 32'h0, 13'd0);

		random_lines(480);
		send_idle_pct = 55;
		take_stall_pct = 9;
		random_lines(480);
		send_idle_pct = 0;
		take_stall_pct = 0;
		random_lines(480);

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pixels_pending != 0) begin
			@(posedge clk);
		end
		repeat (20) @(posedge clk);

		$display("covered %0d line starts and %0d pixel requests under three pressure mixes",
			lines_begun, pixel_requests);
		$display("compared %0d pixels including %0d line ends, %0d mismatches",
			pixels_compared, line_ends, fail_count);
		if (fail_count == 0 && pixels_pending == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("tb_top: FAIL");
		$finish;
	end

endmodule
